/* rtl/core/sacp_pkg.sv */
// Shared types and constants for the set-associative cache with next-line prefetch.
package sacp_pkg;

   localparam int DEF_SETS        = 64;
   localparam int DEF_WAYS        = 4;
   localparam int DEF_BLOCK_BYTES = 64;

   localparam int ADDR_BITS  = 32;
   localparam int STAMP_BITS = 32;

   localparam logic ACTION_WRITE = 1'b1;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPLACE_LRU     = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PREFETCH_ENABLE = 1'b1;

   typedef struct packed {
      logic                 action;
      logic [ADDR_BITS-1:0] address;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] mem_reads;
      logic       mem_write;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic demand;
      logic pf_read;
      logic prefetch;
      logic done;
   } cmd_type;

   typedef struct packed {
      logic pf_go;
   } sts_type;

endpackage

/* rtl/core/sacp_ctrl.sv */
// Sequencer for demand lookup, optional prefetch read and prefetch lookup.
module sacp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  sacp_pkg::sts_type sts,
   output sacp_pkg::cmd_type cmd,
   output logic              busy,
   output logic              rsp_valid
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_DEMAND  = 2'd1;
   localparam logic [1:0] ST_PF_READ = 2'd2;
   localparam logic [1:0] ST_PF_LOOK = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
            if (start) begin
               state_in = ST_DEMAND;
            end
         end
         ST_DEMAND: begin
            cmd.demand = 1'b1;
            if (sts.pf_go) begin
               state_in = ST_PF_READ;
            end else begin
               cmd.done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_PF_READ: begin
            cmd.pf_read = 1'b1;
            state_in    = ST_PF_LOOK;
         end
         ST_PF_LOOK: begin
            cmd.prefetch = 1'b1;
            cmd.done     = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      valid_in = cmd.done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

/* rtl/core/sacp_datapath.sv */
// Tag and stamp stores, valid bits, lookup, victim choice and result register.
module sacp_datapath #(
   parameter int SETS        = sacp_pkg::DEF_SETS,
   parameter int WAYS        = sacp_pkg::DEF_WAYS,
   parameter int BLOCK_BYTES = sacp_pkg::DEF_BLOCK_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sacp_pkg::cmd_type                   cmd,
   output sacp_pkg::sts_type                   sts,
   input  sacp_pkg::req_type                   req_item,
   input  logic                                csr_we,
   input  logic [sacp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sacp_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output sacp_pkg::rsp_type                   rsp_item
);

   localparam int AB           = sacp_pkg::ADDR_BITS;
   localparam int SB           = sacp_pkg::STAMP_BITS;
   localparam int OFF_BITS     = $clog2(BLOCK_BYTES);
   localparam int SET_BITS     = $clog2(SETS);
   localparam int SET_IDX_BITS = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int TAG_BITS     = AB - OFF_BITS - SET_BITS;
   localparam int WAY_BITS     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int TREE         = 1 << WAY_BITS;

   function automatic logic [SET_IDX_BITS-1:0] set_of(input logic [AB-1:0] addr);
      return (SET_BITS == 0) ? '0 : addr[OFF_BITS +: SET_IDX_BITS];
   endfunction

   logic [AB-1:0]               addr_ff;
   logic                        action_ff;
   logic                        lru_ff;
   logic                        pf_en_ff;
   logic [SB-1:0]               cnt_ff, cnt_in;
   logic [SETS-1:0][WAYS-1:0]   valid_ff;
   logic [WAYS-1:0][TAG_BITS-1:0] tag_mem_ff [SETS];
   logic [WAYS-1:0][SB-1:0]       stamp_mem_ff [SETS];
   logic [WAYS-1:0][TAG_BITS-1:0] tag_row_ff, tag_row_in;
   logic [WAYS-1:0][SB-1:0]       stamp_row_ff, stamp_row_in;
   sacp_pkg::rsp_type           rsp_ff, rsp_in;

   logic [AB-1:0]           naddr;
   logic [SET_IDX_BITS-1:0] cur_set, rd_set;
   logic [TAG_BITS-1:0]     cur_tag;
   logic [WAYS-1:0]         valid_row, hit_vec;
   logic                    hit, any_free, active, is_wr, bump, row_wr, fill;
   logic [WAY_BITS-1:0]     hit_way, free_way, victim, way_sel;
   logic [SB-1:0]           stamp_next;
   logic [SB-1:0]           tst [TREE];
   logic [WAY_BITS-1:0]     tix [TREE];

   // Demand block, or the next block when in the prefetch step.
   always_comb begin
      naddr   = addr_ff + AB'(BLOCK_BYTES);
      cur_set = cmd.prefetch ? set_of(naddr) : set_of(addr_ff);
      cur_tag = cmd.prefetch ? naddr[AB-1 -: TAG_BITS] : addr_ff[AB-1 -: TAG_BITS];
      rd_set  = cmd.pf_read ? set_of(naddr) : set_of(req_item.address);
   end

   always_comb begin
      valid_row = valid_ff[cur_set];
      hit_way   = '0;
      free_way  = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         hit_vec[w] = valid_row[w] && (tag_row_ff[w] == cur_tag);
         if (hit_vec[w]) begin
            hit_way = WAY_BITS'(w);
         end
         if (!valid_row[w]) begin
            free_way = WAY_BITS'(w);
         end
      end
      hit      = |hit_vec;
      any_free = ~&valid_row;
   end

   // Oldest stamp by pairwise tree; ties keep the lower way.
   always_comb begin
      for (int i = 0; i < TREE; i++) begin
         tst[i] = (i < WAYS) ? stamp_row_ff[i] : '1;
         tix[i] = WAY_BITS'(i);
      end
      for (int s = 1; s < TREE; s = s * 2) begin
         for (int i = 0; i + s < TREE; i = i + 2 * s) begin
            if (tst[i + s] < tst[i]) begin
               tst[i] = tst[i + s];
               tix[i] = tix[i + s];
            end
         end
      end
      victim = any_free ? free_way : tix[0];
   end

   always_comb begin
      active     = cmd.demand | cmd.prefetch;
      is_wr      = (action_ff == sacp_pkg::ACTION_WRITE);
      fill       = active & !hit;
      bump       = cmd.prefetch | (cmd.demand & (!hit | is_wr | lru_ff));
      row_wr     = fill | (cmd.demand & hit & lru_ff);
      way_sel    = hit ? hit_way : victim;
      stamp_next = cnt_ff + SB'(1);
      cnt_in     = bump ? stamp_next : cnt_ff;

      tag_row_in            = tag_row_ff;
      stamp_row_in          = stamp_row_ff;
      tag_row_in[way_sel]   = cur_tag;
      stamp_row_in[way_sel] = stamp_next;

      sts.pf_go = !hit & pf_en_ff;

      rsp_in = rsp_ff;
      if (cmd.demand) begin
         rsp_in.hit       = hit;
         rsp_in.mem_reads = {1'b0, !hit};
         rsp_in.mem_write = is_wr;
      end else if (cmd.prefetch) begin
         rsp_in.mem_reads = rsp_ff.mem_reads + {1'b0, !hit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lru_ff   <= 1'b1;
         pf_en_ff <= 1'b0;
         cnt_ff   <= '0;
         valid_ff <= '0;
      end else begin
         if (csr_we && csr_index == sacp_pkg::CSR_REPLACE_LRU) begin
            lru_ff <= csr_wdata[0];
         end
         if (csr_we && csr_index == sacp_pkg::CSR_PREFETCH_ENABLE) begin
            pf_en_ff <= csr_wdata[0];
         end
         cnt_ff <= cnt_in;
         if (fill) begin
            valid_ff[cur_set][way_sel] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff   <= req_item.address;
         action_ff <= req_item.action;
      end
      rsp_ff <= rsp_in;
   end

   // Row stores: one row per set, registered read.
   always_ff @(posedge clock) begin
      if (row_wr) begin
         tag_mem_ff[cur_set]   <= tag_row_in;
         stamp_mem_ff[cur_set] <= stamp_row_in;
      end
      tag_row_ff   <= tag_mem_ff[rd_set];
      stamp_row_ff <= stamp_mem_ff[rd_set];
   end

   assign rsp_item = rsp_ff;

endmodule

/* rtl/core/set_assoc_cache_with_prefetch_core.sv */
// Top level of the set-associative cache with LRU/FIFO replacement and next-line prefetch.
//
// Usage:
//   Request: present req_item (action, address) with start high; the beat is
//   taken at a rising edge where start is high and busy is low.
//   Response: one beat per request, rsp_valid high for exactly one cycle with
//   rsp_item (hit, mem_reads, mem_write). The receiver cannot stall; sample it.
//   Config: csr_we with csr_index / csr_wdata writes replace_lru (index 0) or
//   prefetch_enable (index 1); write only while the block is idle.
// Timing:
//   A hit, or a miss with prefetch off: the set row is read on the accept edge
//   and updated in the demand step; rsp_valid follows on the next cycle, during
//   which a new request may already be accepted.
//   A miss with prefetch on adds a prefetch read and lookup: the next set needs
//   its own registered read of the row store before its lookup and update.
//   Throughput is set by that read-modify-write of the tag/stamp row store.
// Reset:
//   Synchronous, active high. Clear all valid bits at once and the stamp
//   counter; replace_lru returns to 1, prefetch_enable to 0. No clearing pass.
//   The user must keep SETS and BLOCK_BYTES powers of two; the block does not enforce it.
module set_assoc_cache_with_prefetch_core #(
   parameter int SETS        = sacp_pkg::DEF_SETS,
   parameter int WAYS        = sacp_pkg::DEF_WAYS,
   parameter int BLOCK_BYTES = sacp_pkg::DEF_BLOCK_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  sacp_pkg::req_type                   req_item,
   output logic                                rsp_valid,
   output sacp_pkg::rsp_type                   rsp_item,
   input  logic                                csr_we,
   input  logic [sacp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sacp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   sacp_pkg::cmd_type cmd;
   sacp_pkg::sts_type sts;

   // Sequence each beat: demand step, then optional prefetch read and lookup.
   sacp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Hold the stores and build the response beat.
   sacp_datapath #(
      .SETS        (SETS),
      .WAYS        (WAYS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_item  (rsp_item)
   );

endmodule

/* tb/tb_set_assoc_cache_with_prefetch_core.sv */
// Self-checking testbench for the set-associative cache core with next-line prefetch.
`timescale 1ns / 1ps

module tb_set_assoc_cache_with_prefetch_core;

   import sacp_pkg::*;

   // Cache geometry at the block's default sizes.
   localparam int SET_COUNT   = DEF_SETS;
   localparam int WAY_COUNT   = DEF_WAYS;
   localparam int BLOCK_SIZE  = DEF_BLOCK_BYTES;
   localparam int LINE_COUNT  = SET_COUNT * WAY_COUNT;
   localparam int OFFSET_BITS = $clog2(BLOCK_SIZE);
   localparam int SET_BITS    = $clog2(SET_COUNT);
   localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - SET_BITS;

   localparam logic ACT_WR = ACTION_WRITE;
   localparam logic ACT_RD = ~ACTION_WRITE;

   // Items per random phase, and the length of the no-idle stretch inside each phase.
   localparam int PHASE_ITEMS   = 225;
   localparam int QUIET_ITEMS   = 80;
   localparam int IDLE_PERCENT  = 23;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_LIMIT   = 2000;

   // Tag store mirror plus the queue of responses still owed by the block.
   class cache_scoreboard;
      bit                  line_present [LINE_COUNT];
      logic [TAG_BITS-1:0] line_tag_q   [LINE_COUNT];
      logic [31:0]         line_age     [LINE_COUNT];
      logic [31:0]         age_clock;
      logic                lru_mode;
      logic                prefetch_on;
      rsp_type             owed_responses [$];
      int                  failures;

      function new();
         foreach (line_present[i]) line_present[i] = 1'b0;
         age_clock   = '0;
         lru_mode    = 1'b1;
         prefetch_on = 1'b0;
         failures    = 0;
      endfunction

      function int pending();
         return owed_responses.size();
      endfunction

      function void apply_setting(logic [CSR_INDEX_BITS-1:0] index,
                                  logic [CSR_DATA_BITS-1:0] value);
         if (index == CSR_REPLACE_LRU)
            lru_mode = value[0];
         else if (index == CSR_PREFETCH_ENABLE)
            prefetch_on = value[0];
      endfunction

      function void locate(input logic [31:0] addr, output int unsigned set_idx,
                           output logic [TAG_BITS-1:0] tag_val);
         logic [31:0] block_num;
         block_num = addr >> OFFSET_BITS;
         set_idx   = block_num % SET_COUNT;
         tag_val   = TAG_BITS'(block_num >> SET_BITS);
      endfunction

      function int lookup(int unsigned set_idx, logic [TAG_BITS-1:0] tag_val);
         int unsigned base;
         base = set_idx * WAY_COUNT;
         for (int w = 0; w < WAY_COUNT; w++)
            if (line_present[base + w] && line_tag_q[base + w] == tag_val)
               return w;
         return -1;
      endfunction

      // Fill the first empty way, else evict the smallest stamp (lowest way on a tie).
      function void allocate(int unsigned set_idx, logic [TAG_BITS-1:0] tag_val);
         int unsigned base;
         int          victim;
         bit          found;
         logic [31:0] oldest;
         base   = set_idx * WAY_COUNT;
         victim = 0;
         found  = 1'b0;
         for (int w = 0; w < WAY_COUNT; w++) begin
            if (!found && !line_present[base + w]) begin
               victim = w;
               found  = 1'b1;
            end
         end
         if (!found) begin
            oldest = line_age[base];
            for (int w = 1; w < WAY_COUNT; w++) begin
               if (line_age[base + w] < oldest) begin
                  oldest = line_age[base + w];
                  victim = w;
               end
            end
         end
         line_present[base + victim] = 1'b1;
         line_tag_q[base + victim]   = tag_val;
         line_age[base + victim]     = age_clock;
      endfunction

      function void note_access(req_type beat);
         int unsigned         set_idx;
         int unsigned         next_set;
         logic [TAG_BITS-1:0] tag_val;
         logic [TAG_BITS-1:0] next_tag;
         logic [31:0]         next_addr;
         int                  way;
         rsp_type             want;
         want           = '0;
         want.mem_write = (beat.action == ACTION_WRITE);
         locate(beat.address, set_idx, tag_val);
         way = lookup(set_idx, tag_val);
         if (way >= 0) begin
            want.hit = 1'b1;
            // writes always tick the stamp clock; reads only in LRU mode
            if (want.mem_write || lru_mode) begin
               age_clock++;
               if (lru_mode)
                  line_age[set_idx * WAY_COUNT + way] = age_clock;
            end
         end else begin
            age_clock++;
            allocate(set_idx, tag_val);
            want.mem_reads = 2'd1;
            if (prefetch_on) begin
               next_addr = beat.address + 32'(BLOCK_SIZE);
               locate(next_addr, next_set, next_tag);
               age_clock++;
               if (lookup(next_set, next_tag) < 0) begin
                  allocate(next_set, next_tag);
                  want.mem_reads = 2'd2;
               end
            end
         end
         owed_responses.push_back(want);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (owed_responses.size() == 0) begin
            $error("response beat with nothing outstanding: %p", got);
            failures++;
            return;
         end
         want = owed_responses.pop_front();
         if (got.hit !== want.hit) begin
            $error("hit mismatch: expected %0d, actual %0d", want.hit, got.hit);
            failures++;
         end
         if (got.mem_reads !== want.mem_reads) begin
            $error("mem_reads mismatch: expected %0d, actual %0d",
                   want.mem_reads, got.mem_reads);
            failures++;
         end
         if (got.mem_write !== want.mem_write) begin
            $error("mem_write mismatch: expected %0d, actual %0d",
                   want.mem_write, got.mem_write);
            failures++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   req_type                   req_item;
   logic                      rsp_valid;
   rsp_type                   rsp_item;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   cache_scoreboard sb;
   int unsigned     idle_pct;
   logic [31:0]     stream_addr;

   // Directed beats, run with LRU and prefetch on:
   //   cold miss that prefetches, hit on the prefetched line, write hit, miss at the
   //   top address whose next block wraps onto a line already held, write hit on that
   //   block, write miss, then five tags into one set with an LRU refresh before eviction.
   req_type directed_beats [] = '{
      {ACT_RD, 32'h0000_0000}, {ACT_RD, 32'h0000_0040}, {ACT_WR, 32'h0000_0000},
      {ACT_RD, 32'hFFFF_FFFF}, {ACT_WR, 32'hFFFF_FFC0}, {ACT_WR, 32'h0000_1000},
      {ACT_RD, 32'h0000_0140}, {ACT_RD, 32'h0000_1140}, {ACT_RD, 32'h0000_2140},
      {ACT_RD, 32'h0000_3140}, {ACT_RD, 32'h0000_0140}, {ACT_RD, 32'h0000_4140},
      {ACT_RD, 32'h0000_1140}, {ACT_WR, 32'h0000_0140}, {ACT_WR, 32'hFFFF_FFFF},
      {ACT_RD, 32'h0000_0000}
   };

   set_assoc_cache_with_prefetch_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Sample the response at the edge that ends its cycle; the receiver never stalls.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_item);
   end

   // Backstop: end the run if the block hangs.
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [31:0] make_address(int unsigned tag_val, int unsigned set_idx,
                                                int unsigned offset);
      return (tag_val << (SET_BITS + OFFSET_BITS)) | (set_idx << OFFSET_BITS) | offset;
   endfunction

   // Offer one request beat, with an optional idle gap first; return on the accept edge.
   // Leave start high so back-to-back beats need no second assignment in one step.
   task automatic drive_access(input logic act, input logic [31:0] addr);
      req_type beat;
      beat.action  = act;
      beat.address = addr;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start    <= 1'b1;
      req_item <= beat;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_access(beat);
   endtask

   // Drop start, let every owed response land, then write both registers.
   task automatic write_settings(input logic lru, input logic pf);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_REPLACE_LRU;
      csr_wdata <= lru;
      @(posedge clock);
      sb.apply_setting(CSR_REPLACE_LRU, lru);
      csr_index <= CSR_PREFETCH_ENABLE;
      csr_wdata <= pf;
      @(posedge clock);
      sb.apply_setting(CSR_PREFETCH_ENABLE, pf);
      csr_we <= 1'b0;
   endtask

   // Mostly local traffic so sets fill, hit and evict; the rest is wide noise.
   task automatic run_random(input int count);
      logic [31:0] addr;
      int unsigned pick;
      for (int i = 0; i < count; i++) begin
         // hold a stretch with no idle gaps at all
         idle_pct = (i >= count / 3 && i < count / 3 + QUIET_ITEMS) ? 0 : IDLE_PERCENT;
         pick = $urandom_range(99);
         if (pick < 35)
            // hot sets: eight tags fighting over four ways
            addr = make_address($urandom_range(7), $urandom_range(3),
                                $urandom_range(BLOCK_SIZE - 1));
         else if (pick < 55)
            // sequential stream: the next block is what a prefetch brings in
            addr = stream_addr + 32'(BLOCK_SIZE);
         else if (pick < 70)
            // same block again at another offset
            addr = stream_addr ^ 32'($urandom_range(BLOCK_SIZE - 1));
         else if (pick < 82)
            // top of the address space, where the next block wraps to zero
            addr = make_address((1 << TAG_BITS) - 1 - $urandom_range(1),
                                SET_COUNT - 1 - $urandom_range(1),
                                $urandom_range(BLOCK_SIZE - 1));
         else
            addr = $urandom();
         stream_addr = addr;
         drive_access(1'($urandom_range(1)), addr);
      end
      idle_pct = IDLE_PERCENT;
   endtask

   initial begin
      int waited;
      sb          = new();
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      idle_pct    = IDLE_PERCENT;
      stream_addr = '0;
      waited      = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      write_settings(1'b1, 1'b1);
      foreach (directed_beats[i])
         drive_access(directed_beats[i].action, directed_beats[i].address);

      // Sweep every combination of replacement policy and prefetch.
      write_settings(1'b0, 1'b0);
      run_random(PHASE_ITEMS);
      write_settings(1'b1, 1'b1);
      run_random(PHASE_ITEMS);
      write_settings(1'b0, 1'b1);
      run_random(PHASE_ITEMS);
      write_settings(1'b1, 1'b0);
      run_random(PHASE_ITEMS);

      // Drain with a bound, then keep watching for stray beats.
      start <= 1'b0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d responses never arrived", sb.pending());
         sb.failures++;
      end

      if (sb.failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
